[hw/rtl/brush_tire_lateral_force_top_macros.svh]
// Assertion helpers for the lateral force block.
`ifndef BRUSH_TIRE_LATERAL_FORCE_TOP_MACROS_SVH
`define BRUSH_TIRE_LATERAL_FORCE_TOP_MACROS_SVH

// Implication checked outside reset.
`define BTLF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks what a reset cycle leaves behind on the next edge.
`define BTLF_ASSERT_RST(label, clk, rst_n, cons, msg) \
    label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/btlf_pkg.sv]
`default_nettype none
package btlf_pkg;

    localparam int ANG_W        = 15;
    localparam int TAN_W        = 32;
    localparam int CORD_W       = 33;
    localparam int CORDIC_STEPS = 30;
    localparam int TDIV_STEPS   = 32;
    localparam int ISQ_STEPS    = 29;
    localparam int SDIV_STEPS   = 24;
    localparam int PEAK_W       = 25;
    localparam int DIV_W        = 27;

    localparam int TAN_LAT   = CORDIC_STEPS + TDIV_STEPS + 3;
    localparam int PEAK_LAT  = ISQ_STEPS + 5;
    localparam int PEAK_DLY  = TAN_LAT - PEAK_LAT;
    localparam int SHAPE_LAT = SDIV_STEPS + 6;

    localparam logic [ANG_W-1:0]         ANGLE_MAX = 15'd25735;
    localparam logic signed [CORD_W-1:0] CORD_X0   = 33'sd1073741824;
    localparam logic [PEAK_W-1:0]        ONE_Q24   = 25'd16777216;
    localparam logic [50:0]              HALF_Q24  = 51'd8388608;

    localparam logic [1:0] CFG_CA = 2'd0;
    localparam logic [1:0] CFG_MU = 2'd1;
    localparam logic [1:0] CFG_FB = 2'd2;

    localparam logic [23:0] CA_RST = 24'd100000;
    localparam logic [15:0] MU_RST = 16'd16384;
    localparam logic [22:0] FB_RST = 23'd16000;

    typedef struct packed {
        logic pos;
        logic neg;
    } t_sign;

    typedef struct packed {
        logic [PEAK_W-1:0] peak;
        logic              fb;
    } t_peak;

    typedef struct packed {
        logic [PEAK_W-1:0] peak;
        logic              fb;
        logic              pos;
        logic              neg;
        logic              cub;
    } t_ctl;

    // atan(2^-i) in Q30
    function automatic logic signed [CORD_W-1:0] atan_q30(input int idx);
        logic signed [CORD_W-1:0] v;
        case (idx)
            0:  v = 33'sd843314857;
            1:  v = 33'sd497837829;
            2:  v = 33'sd263043837;
            3:  v = 33'sd133525159;
            4:  v = 33'sd67021687;
            5:  v = 33'sd33543516;
            6:  v = 33'sd16775851;
            7:  v = 33'sd8388437;
            8:  v = 33'sd4194283;
            9:  v = 33'sd2097149;
            10: v = 33'sd1048576;
            11: v = 33'sd524288;
            12: v = 33'sd262144;
            13: v = 33'sd131072;
            14: v = 33'sd65536;
            15: v = 33'sd32768;
            16: v = 33'sd16384;
            17: v = 33'sd8192;
            18: v = 33'sd4096;
            19: v = 33'sd2048;
            20: v = 33'sd1024;
            21: v = 33'sd512;
            22: v = 33'sd256;
            23: v = 33'sd128;
            24: v = 33'sd64;
            25: v = 33'sd32;
            26: v = 33'sd16;
            27: v = 33'sd8;
            28: v = 33'sd4;
            29: v = 33'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/btlf_tan.sv]
`default_nettype none
// tan(a) in Q16.16: CORDIC rotation, one step per stage, then a
// restoring divider, one quotient bit per stage.
module btlf_tan (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [btlf_pkg::ANG_W-1:0]    i_angle,
    output logic                          o_valid,
    output logic [btlf_pkg::TAN_W-1:0]    o_tan
);
    import btlf_pkg::*;

    logic signed [CORD_W-1:0] r_x [0:CORDIC_STEPS];
    logic signed [CORD_W-1:0] r_y [0:CORDIC_STEPS];
    logic signed [CORD_W-1:0] r_z [0:CORDIC_STEPS];
    logic signed [CORD_W-1:0] n_x [1:CORDIC_STEPS];
    logic signed [CORD_W-1:0] n_y [1:CORDIC_STEPS];
    logic signed [CORD_W-1:0] n_z [1:CORDIC_STEPS];
    logic [CORDIC_STEPS:0]    r_cv;

    logic [TAN_W-1:0] r_dr [0:TDIV_STEPS];
    logic [TAN_W-1:0] r_dd [0:TDIV_STEPS];
    logic [TAN_W-1:0] r_dq [0:TDIV_STEPS];
    logic [15:0]      r_dl [0:TDIV_STEPS];
    logic [TAN_W-1:0] n_dr [1:TDIV_STEPS];
    logic [TAN_W-1:0] n_dq [1:TDIV_STEPS];
    logic [TDIV_STEPS:0] r_dv;
    logic [TDIV_STEPS:0] r_dm;
    logic [TDIV_STEPS:0] r_dz;

    logic signed [CORD_W-1:0] w_x;
    logic signed [CORD_W-1:0] w_y;
    logic n_psat;
    logic n_pzero;
    logic n_povf;
    logic [TAN_W-1:0] r_t;
    logic             r_tv;

    always_comb begin
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (!r_z[i][CORD_W-1]) begin
                n_x[i+1] = r_x[i] - (r_y[i] >>> i);
                n_y[i+1] = r_y[i] + (r_x[i] >>> i);
                n_z[i+1] = r_z[i] - atan_q30(i);
            end else begin
                n_x[i+1] = r_x[i] + (r_y[i] >>> i);
                n_y[i+1] = r_y[i] - (r_x[i] >>> i);
                n_z[i+1] = r_z[i] + atan_q30(i);
            end
        end
    end

    // x <= 0 forces all ones, y < 0 forces zero, y/x >= 2^16 overflows
    assign w_x     = r_x[CORDIC_STEPS];
    assign w_y     = r_y[CORDIC_STEPS];
    assign n_psat  = w_x[CORD_W-1] || (w_x == '0);
    assign n_pzero = w_y[CORD_W-1];
    assign n_povf  = {16'b0, w_y[31:16]} >= w_x[31:0];

    always_comb begin
        logic [TAN_W:0] rs;
        for (int k = 0; k < TDIV_STEPS; k++) begin
            rs = {r_dr[k], r_dl[k][15]};
            if (rs >= {1'b0, r_dd[k]}) begin
                n_dr[k+1] = TAN_W'(rs - {1'b0, r_dd[k]});
                n_dq[k+1] = {r_dq[k][TAN_W-2:0], 1'b1};
            end else begin
                n_dr[k+1] = rs[TAN_W-1:0];
                n_dq[k+1] = {r_dq[k][TAN_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0] <= CORD_X0;
        r_y[0] <= '0;
        r_z[0] <= {2'b0, i_angle, 16'b0};
        for (int i = 1; i <= CORDIC_STEPS; i++) begin
            r_x[i] <= n_x[i];
            r_y[i] <= n_y[i];
            r_z[i] <= n_z[i];
        end
        r_dr[0] <= {16'b0, w_y[31:16]};
        r_dd[0] <= w_x[31:0];
        r_dq[0] <= '0;
        r_dl[0] <= w_y[15:0];
        r_dm    <= {r_dm[TDIV_STEPS-1:0], n_psat || (!n_pzero && n_povf)};
        r_dz    <= {r_dz[TDIV_STEPS-1:0], !n_psat && n_pzero};
        for (int k = 1; k <= TDIV_STEPS; k++) begin
            r_dr[k] <= n_dr[k];
            r_dq[k] <= n_dq[k];
            r_dd[k] <= r_dd[k-1];
            r_dl[k] <= {r_dl[k-1][14:0], 1'b0};
        end
        if (r_dm[TDIV_STEPS]) begin
            r_t <= '1;
        end else if (r_dz[TDIV_STEPS]) begin
            r_t <= '0;
        end else begin
            r_t <= r_dq[TDIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv <= '0;
            r_dv <= '0;
            r_tv <= 1'b0;
        end else begin
            r_cv <= {r_cv[CORDIC_STEPS-1:0], i_valid};
            r_dv <= {r_dv[TDIV_STEPS-1:0], r_cv[CORDIC_STEPS]};
            r_tv <= r_dv[TDIV_STEPS];
        end
    end

    assign o_valid = r_tv;
    assign o_tan   = r_t;

endmodule
`default_nettype wire

[hw/rtl/btlf_peak.sv]
`default_nettype none
// Friction-ellipse peak force: squares, then a digit-by-digit square root.
module btlf_peak (
    input  logic                 i_clk,
    input  logic [22:0]          i_fz,
    input  logic [23:0]          i_fxmag,
    input  logic [15:0]          i_mu,
    input  logic [22:0]          i_fbpk,
    output btlf_pkg::t_peak      o_peak
);
    import btlf_pkg::*;

    logic [38:0] r_m1;
    logic [23:0] r_fx1;
    logic        r_gt2;
    logic [28:0] r_mq2;
    logic [27:0] r_xq2;
    logic        r_gt3;
    logic [57:0] r_mqs3;
    logic [55:0] r_xqs3;
    logic [39:0] w_mr;

    logic [57:0] r_sv [0:ISQ_STEPS];
    logic [30:0] r_rm [0:ISQ_STEPS];
    logic [28:0] r_rt [0:ISQ_STEPS];
    logic [30:0] n_rm [1:ISQ_STEPS];
    logic [28:0] n_rt [1:ISQ_STEPS];
    logic [ISQ_STEPS:0] r_sg;
    t_peak r_pk;

    assign w_mr = {1'b0, r_m1} + 40'd512;

    always_comb begin
        logic [32:0] rs;
        logic [32:0] tr;
        for (int k = 0; k < ISQ_STEPS; k++) begin
            rs = {r_rm[k], r_sv[k][57:56]};
            tr = {2'b0, r_rt[k], 2'b01};
            if (rs >= tr) begin
                n_rm[k+1] = 31'(rs - tr);
                n_rt[k+1] = {r_rt[k][27:0], 1'b1};
            end else begin
                n_rm[k+1] = rs[30:0];
                n_rt[k+1] = {r_rt[k][27:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_m1   <= 39'(i_mu * i_fz);
        r_fx1  <= i_fxmag;
        r_gt2  <= r_m1 > {1'b0, r_fx1, 14'b0};
        r_mq2  <= w_mr[38:10];
        r_xq2  <= {r_fx1, 4'b0};
        r_gt3  <= r_gt2;
        r_mqs3 <= r_mq2 * r_mq2;
        r_xqs3 <= r_xq2 * r_xq2;
        r_sv[0] <= r_mqs3 - {2'b0, r_xqs3};
        r_rm[0] <= '0;
        r_rt[0] <= '0;
        r_sg    <= {r_sg[ISQ_STEPS-1:0], r_gt3};
        for (int k = 1; k <= ISQ_STEPS; k++) begin
            r_sv[k] <= {r_sv[k-1][55:0], 2'b0};
            r_rm[k] <= n_rm[k];
            r_rt[k] <= n_rt[k];
        end
        if (r_sg[ISQ_STEPS]) begin
            r_pk.peak <= r_rt[ISQ_STEPS][28:4];
            r_pk.fb   <= 1'b0;
        end else begin
            r_pk.peak <= {2'b0, i_fbpk};
            r_pk.fb   <= 1'b1;
        end
    end

    assign o_peak = r_pk;

endmodule
`default_nettype wire

[hw/rtl/btlf_shape.sv]
`default_nettype none
// Brush curve: U = Ca*T, branch test, r = U*4096/(3F) one bit per stage,
// then the cubic F*(1-(1-r)^3) over three multiplier stages.
module btlf_shape (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [btlf_pkg::TAN_W-1:0]    i_tan,
    input  btlf_pkg::t_peak               i_peak,
    input  btlf_pkg::t_sign               i_sign,
    input  logic [23:0]                   i_ca,
    output logic                          o_valid,
    output logic signed [23:0]            o_lateral_force,
    output logic                          o_is_saturated,
    output logic                          o_used_fallback
);
    import btlf_pkg::*;

    logic [55:0]      r_u1;
    logic [DIV_W-1:0] r_d1;
    t_ctl             r_c1;
    logic             r_v1;

    logic [DIV_W-1:0] r_r  [0:SDIV_STEPS];
    logic [DIV_W-1:0] r_d  [0:SDIV_STEPS];
    logic [23:0]      r_q  [0:SDIV_STEPS];
    logic [11:0]      r_lo [0:SDIV_STEPS];
    t_ctl             r_c  [0:SDIV_STEPS];
    logic [DIV_W-1:0] n_r  [1:SDIV_STEPS];
    logic [23:0]      n_q  [1:SDIV_STEPS];
    logic [SDIV_STEPS:0] r_vv;

    logic [PEAK_W-1:0] w_s;
    logic [49:0]       w_ss;
    logic [49:0]       w_s3p;
    logic [49:0]       w_mp;
    logic [50:0]       w_mr;
    logic [PEAK_W-1:0] r_s5;
    logic [PEAK_W-1:0] r_s25;
    t_ctl              r_c5;
    logic              r_v5;
    logic [PEAK_W-1:0] r_s36;
    t_ctl              r_c6;
    logic              r_v6;
    logic [PEAK_W-1:0] r_mag7;
    t_ctl              r_c7;
    logic              r_v7;
    logic [23:0]       r_fy;
    logic              r_sat;
    logic              r_fb;
    logic              r_vo;

    always_comb begin
        logic [DIV_W:0] rs;
        for (int k = 0; k < SDIV_STEPS; k++) begin
            rs = {r_r[k], r_lo[k][11]};
            if (rs >= {1'b0, r_d[k]}) begin
                n_r[k+1] = DIV_W'(rs - {1'b0, r_d[k]});
                n_q[k+1] = {r_q[k][22:0], 1'b1};
            end else begin
                n_r[k+1] = rs[DIV_W-1:0];
                n_q[k+1] = {r_q[k][22:0], 1'b0};
            end
        end
    end

    assign w_s   = ONE_Q24 - {1'b0, r_q[SDIV_STEPS]};
    assign w_ss  = w_s * w_s;
    assign w_s3p = r_s25 * r_s5;
    assign w_mp  = r_c6.peak * (ONE_Q24 - r_s36);
    assign w_mr  = {1'b0, w_mp} + HALF_Q24;

    always_ff @(posedge i_clk) begin
        r_u1      <= 56'(i_ca * i_tan);
        r_d1      <= {2'b0, i_peak.peak} + {1'b0, i_peak.peak, 1'b0};
        r_c1.peak <= i_peak.peak;
        r_c1.fb   <= i_peak.fb;
        r_c1.pos  <= i_sign.pos;
        r_c1.neg  <= i_sign.neg;
        r_c1.cub  <= 1'b0;

        // cubic branch when U < 3F * 4096; then U >> 12 < 3F starts the divide
        r_r[0]     <= r_u1[38:12];
        r_lo[0]    <= r_u1[11:0];
        r_q[0]     <= '0;
        r_d[0]     <= r_d1;
        r_c[0]     <= {r_c1[$bits(t_ctl)-1:1], r_u1 < {17'b0, r_d1, 12'b0}};
        for (int k = 1; k <= SDIV_STEPS; k++) begin
            r_r[k]  <= n_r[k];
            r_q[k]  <= n_q[k];
            r_d[k]  <= r_d[k-1];
            r_lo[k] <= {r_lo[k-1][10:0], 1'b0};
            r_c[k]  <= r_c[k-1];
        end

        r_s5  <= w_s;
        r_s25 <= w_ss[48:24];
        r_c5  <= r_c[SDIV_STEPS];
        r_s36 <= w_s3p[48:24];
        r_c6  <= r_c5;
        r_mag7 <= r_c6.cub ? w_mr[48:24] : r_c6.peak;
        r_c7   <= r_c6;

        r_sat <= !r_c7.cub;
        r_fb  <= r_c7.fb;
        if (r_c7.pos) begin
            r_fy <= (r_mag7 > 25'd8388608) ? 24'h800000 : 24'(25'd0 - r_mag7);
        end else if (r_c7.neg) begin
            r_fy <= (r_mag7 > 25'd8388607) ? 24'h7FFFFF : r_mag7[23:0];
        end else begin
            r_fy <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_vv <= '0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_vv <= {r_vv[SDIV_STEPS-1:0], r_v1};
            r_v5 <= r_vv[SDIV_STEPS];
            r_v6 <= r_v5;
            r_v7 <= r_v6;
            r_vo <= r_v7;
        end
    end

    assign o_valid         = r_vo;
    assign o_lateral_force = $signed(r_fy);
    assign o_is_saturated  = r_sat;
    assign o_used_fallback = r_fb;

endmodule
`default_nettype wire

[hw/rtl/brush_tire_lateral_force_top.sv]
`default_nettype none
// Brush tire lateral force, fully pipelined. One sample is taken in every
// clock cycle (busy is always low) and its result appears on o_strobe and
// the result ports for exactly one cycle; results leave in input order and
// cannot be held off, so the receiver must take every strobe. The latency
// is set by the 30-step CORDIC tangent, its 32-bit quotient divider and the
// 24-bit branch divider, each one stage per step. Configuration registers
// are written through the i_cfg_* port and may only change while no sample
// is in flight.
module brush_tire_lateral_force_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_slip_angle,
    input  logic signed [23:0] i_long_force,
    input  logic [22:0]        i_normal_load,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_addr,
    input  logic [23:0]        i_cfg_wdata,
    output logic               o_strobe,
    output logic signed [23:0] o_lateral_force,
    output logic               o_is_saturated,
    output logic               o_used_fallback
);
    import btlf_pkg::*;

    // configuration
    logic [23:0] r_ca;
    logic [15:0] r_mu;
    logic [22:0] r_fbpk;

    // input stage
    logic [16:0]      w_amag_full;
    logic [ANG_W-1:0] n_amag;
    logic [23:0]      n_fxmag;
    t_sign            n_sg;
    logic             r_in_v;
    logic [ANG_W-1:0] r_amag;
    logic [23:0]      r_fxmag;
    logic [22:0]      r_fz;
    t_sign            r_in_sg;

    // alignment
    t_sign r_sgd [0:TAN_LAT-1];
    t_peak r_pkd [0:PEAK_DLY-1];
    t_peak w_peak;
    logic             w_tan_v;
    logic [TAN_W-1:0] w_tan;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ca   <= CA_RST;
            r_mu   <= MU_RST;
            r_fbpk <= FB_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_CA:  r_ca   <= i_cfg_wdata;
                CFG_MU:  r_mu   <= i_cfg_wdata[15:0];
                CFG_FB:  r_fbpk <= i_cfg_wdata[22:0];
                default: ;
            endcase
        end
    end

    // |alpha| clamped to just under pi/2, |fx| and the sign of alpha
    assign w_amag_full = i_slip_angle[15] ? (17'd0 - {1'b1, $unsigned(i_slip_angle)})
                                          : {1'b0, $unsigned(i_slip_angle)};
    assign n_amag  = (w_amag_full > {2'b0, ANGLE_MAX}) ? ANGLE_MAX : w_amag_full[ANG_W-1:0];
    assign n_fxmag = i_long_force[23] ? (24'd0 - $unsigned(i_long_force))
                                      : $unsigned(i_long_force);
    assign n_sg.pos = !i_slip_angle[15] && (i_slip_angle != 16'sd0);
    assign n_sg.neg = i_slip_angle[15];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else begin
            r_in_v <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_amag  <= n_amag;
        r_fxmag <= n_fxmag;
        r_fz    <= i_normal_load;
        r_in_sg <= n_sg;
    end

    btlf_tan u_tan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_v),
        .i_angle (r_amag),
        .o_valid (w_tan_v),
        .o_tan   (w_tan)
    );

    t_peak w_pk_raw;

    btlf_peak u_peak (
        .i_clk   (i_clk),
        .i_fz    (r_fz),
        .i_fxmag (r_fxmag),
        .i_mu    (r_mu),
        .i_fbpk  (r_fbpk),
        .o_peak  (w_pk_raw)
    );

    // the peak path is shorter than the tangent path; line both up
    always_ff @(posedge i_clk) begin
        r_sgd[0] <= r_in_sg;
        for (int i = 1; i < TAN_LAT; i++) begin
            r_sgd[i] <= r_sgd[i-1];
        end
        r_pkd[0] <= w_pk_raw;
        for (int i = 1; i < PEAK_DLY; i++) begin
            r_pkd[i] <= r_pkd[i-1];
        end
    end

    assign w_peak = r_pkd[PEAK_DLY-1];

    btlf_shape u_shape (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_tan_v),
        .i_tan           (w_tan),
        .i_peak          (w_peak),
        .i_sign          (r_sgd[TAN_LAT-1]),
        .i_ca            (r_ca),
        .o_valid         (o_strobe),
        .o_lateral_force (o_lateral_force),
        .o_is_saturated  (o_is_saturated),
        .o_used_fallback (o_used_fallback)
    );

`include "brush_tire_lateral_force_top_macros.svh"

    `BTLF_ASSERT_IMP(a_tan_lat, i_clk, i_rst_n, w_tan_v, $past(r_in_v, TAN_LAT), "tangent path out of step with input stage")
    `BTLF_ASSERT_IMP(a_shape_lat, i_clk, i_rst_n, o_strobe, $past(w_tan_v, SHAPE_LAT), "result strobe without a tangent transaction")
    `BTLF_ASSERT_IMP(a_fb_slide, i_clk, i_rst_n, o_strobe && o_used_fallback && o_is_saturated, (o_lateral_force == 24'sd0) || (o_lateral_force == $signed({1'b0, r_fbpk})) || (o_lateral_force == -$signed({1'b0, r_fbpk})), "sliding fallback force differs from configured peak")
    `BTLF_ASSERT_RST(a_rst_clear, i_clk, i_rst_n, !o_strobe && !w_tan_v && !r_in_v, "reset left a transaction in flight")

endmodule
`default_nettype wire

[dv/brush_tire_lateral_force_top_tb.sv]
`timescale 1ns / 100ps
`default_nettype none
// Self-checking bench for the brush tire lateral force pipeline.
// A directed table runs first at the reset settings, then random samples
// under several register settings (extremes included), with and without sender gaps.
module brush_tire_lateral_force_top_tb;
    import btlf_pkg::*;

    // one lateral force result as the block reports it
    typedef struct packed {
        logic signed [23:0] fy;
        logic               sat;
        logic               fb;
    } t_tire_res;

    // directed row: sample fields plus, where obvious, the typed-in answer
    typedef struct packed {
        logic signed [15:0] slip;
        logic signed [23:0] fx;
        logic [22:0]        fz;
        logic               typed;
        t_tire_res          res;
    } t_row;

    localparam int N_ROWS = 16;
    localparam int PHASE_ITEMS = 220;
    localparam int LAT_WAIT = 120;   // a bit over the pipeline depth

    // idle modes of the sender
    localparam int GAP_LIGHT = 22;
    localparam int GAP_HEAVY = 67;
    localparam int GAP_NONE  = 0;

    // atan(2^-i) in Q30, own copy
    localparam longint ATAN_TBL [0:29] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2};

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [15:0] i_slip_angle;
    logic signed [23:0] i_long_force;
    logic [22:0]        i_normal_load;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_addr;
    logic [23:0]        i_cfg_wdata;
    logic               o_strobe;
    logic signed [23:0] o_lateral_force;
    logic               o_is_saturated;
    logic               o_used_fallback;

    // side band: typed expectation travels with the sample
    logic      row_typed;
    t_tire_res row_res;

    // shadow of the configuration registers
    logic [23:0] stiff_sh;
    logic [15:0] mu_sh;
    logic [22:0] fbpk_sh;

    t_tire_res force_q[$];
    int        n_err;
    int        n_sent;
    int        n_got;
    int        n_slide;
    int        n_fallback;
    int        n_settings;

    brush_tire_lateral_force_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_slip_angle   (i_slip_angle),
        .i_long_force   (i_long_force),
        .i_normal_load  (i_normal_load),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_strobe       (o_strobe),
        .o_lateral_force(o_lateral_force),
        .o_is_saturated (o_is_saturated),
        .o_used_fallback(o_used_fallback)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // hard stop in case the pipeline hangs
    initial begin
        #3ms;
        $display("Timeout at %0t", $realtime);
        $display("Mismatches found");
        $finish;
    end

    // Fiala brush model in fixed point: friction-ellipse peak, CORDIC tangent,
    // cubic or sliding branch, sign opposite to the slip, output clamp.
    function automatic t_tire_res lateral_force_of(logic signed [15:0] slip,
                                                   logic signed [23:0] fx,
                                                   logic [22:0] fz);
        t_tire_res         r;
        longint            amag, fxmag, x, y, z, dx, dy, tq;
        longint unsigned   m_fric, x_fric, mq, xq, v, root, bitv, peak;
        longint unsigned   u, lim, ratio, s, s2, s3, mag;
        r.sat = 1'b0;
        r.fb  = 1'b0;
        amag = slip;
        if (amag < 0) amag = -amag;
        if (amag > 25735) amag = 25735;
        fxmag = fx;
        if (fxmag < 0) fxmag = -fxmag;

        // friction ellipse derating of the peak
        m_fric = longint'(mu_sh) * longint'(fz);
        x_fric = longint'(fxmag) << 14;
        if (m_fric > x_fric) begin
            mq = (m_fric + 512) >> 10;
            xq = longint'(fxmag) << 4;
            v = mq * mq - xq * xq;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv >>= 2;
            while (bitv != 0) begin
                if (v >= root + bitv) begin
                    v = v - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root >>= 1;
                end
                bitv >>= 2;
            end
            peak = root >> 4;
        end else begin
            peak = fbpk_sh;
            r.fb = 1'b1;
        end

        // tangent in Q16.16 via rotation-mode CORDIC
        x = 64'sd1 << 30;
        y = 0;
        z = amag * 65536;
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - ATAN_TBL[i];
            end else begin
                x = x + dx; y = y - dy; z = z + ATAN_TBL[i];
            end
        end
        if (x <= 0) tq = 64'hFFFF_FFFF;
        else if (y < 0) tq = 0;
        else begin
            tq = (y <<< 16) / x;
            if (tq > 64'hFFFF_FFFF) tq = 64'hFFFF_FFFF;
        end

        u = longint'(stiff_sh) * longint'(tq);
        lim = 3 * peak * 4096;
        if (u < lim) begin
            ratio = (u << 12) / (3 * peak);
            s = (64'd1 << 24) - ratio;
            s2 = (s * s) >> 24;
            s3 = (s2 * s) >> 24;
            mag = (peak * ((64'd1 << 24) - s3) + (64'd1 << 23)) >> 24;
        end else begin
            mag = peak;
            r.sat = 1'b1;
        end

        if (slip > 0) begin
            if (mag > 8388608) mag = 8388608;
            r.fy = 24'(-longint'(mag));
        end else if (slip < 0) begin
            if (mag > 8388607) mag = 8388607;
            r.fy = 24'(mag);
        end else begin
            r.fy = '0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        $display("%0t ERROR %s: got %0d expected %0d", $realtime, what, got, want);
        n_err++;
    endtask

    // queue the expectation of every accepted transaction
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            if (row_typed) force_q.push_back(row_res);
            else force_q.push_back(lateral_force_of(i_slip_angle, i_long_force,
                                                    i_normal_load));
        end
    end

    // compare each result strobe with the oldest expectation
    always @(posedge i_clk) begin
        t_tire_res want;
        if (i_rst_n && o_strobe) begin
            n_got++;
            if (o_is_saturated) n_slide++;
            if (o_used_fallback) n_fallback++;
            if (force_q.size() == 0) begin
                report_mismatch("result with nothing expected", o_lateral_force, 0);
            end else begin
                want = force_q.pop_front();
                if (o_lateral_force !== want.fy)
                    report_mismatch("lateral_force", o_lateral_force, want.fy);
                if (o_is_saturated !== want.sat)
                    report_mismatch("is_saturated", o_is_saturated, want.sat);
                if (o_used_fallback !== want.fb)
                    report_mismatch("used_fallback", o_used_fallback, want.fb);
            end
        end
    end

    // register write; only called with the pipeline drained
    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_CA: stiff_sh = val;
            CFG_MU: mu_sh    = val[15:0];
            CFG_FB: fbpk_sh  = val[22:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [23:0] ca, input logic [15:0] mu,
                                 input logic [22:0] fbp);
        write_reg(CFG_CA, ca);
        write_reg(CFG_MU, {8'd0, mu});
        write_reg(CFG_FB, {1'b0, fbp});
        n_settings++;
    endtask

    // wait for all results, then let the pipeline settle
    task automatic drain();
        while (force_q.size() != 0) @(posedge i_clk);
        repeat (LAT_WAIT) @(posedge i_clk);
    endtask

    // one transaction; start stays high across back-to-back samples
    task automatic send(input logic signed [15:0] slip, input logic signed [23:0] fx,
                        input logic [22:0] fz, input logic typed, input t_tire_res res,
                        input int gap_pct);
        if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_slip_angle  <= slip;
        i_long_force  <= fx;
        i_normal_load <= fz;
        row_typed     <= typed;
        row_res       <= res;
        do @(posedge i_clk); while (busy);
        n_sent++;
    endtask

    // log-spread random value so small and large magnitudes both show up
    function automatic logic [31:0] spread(input int width);
        logic [31:0] mask;
        mask = (32'd1 << $urandom_range(1, width)) - 1;
        return $urandom & mask;
    endfunction

    task automatic random_phase(input int gap_pct);
        logic signed [15:0] slip;
        logic signed [23:0] fx;
        logic [22:0]        fz;
        for (int k = 0; k < PHASE_ITEMS; k++) begin
            case ($urandom_range(3))
                0:       slip = 16'($urandom);                  // full range incl. -32768
                1:       slip = 16'($urandom_range(25735, 32767));
                default: slip = 16'(spread(15));
            endcase
            if ($urandom_range(1)) slip = -slip;
            fx = $urandom_range(3) == 0 ? 24'($urandom) : 24'(spread(23));
            if ($urandom_range(1)) fx = -fx;
            fz = $urandom_range(3) == 0 ? 23'($urandom) : 23'(spread(23));
            send(slip, fx, fz, 1'b0, '0, gap_pct);
        end
        start <= 1'b0;
    endtask

    t_row dir_rows [N_ROWS];

    initial begin
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_slip_angle  = '0;
        i_long_force  = '0;
        i_normal_load = '0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = CFG_CA;
        i_cfg_wdata   = '0;
        row_typed     = 1'b0;
        row_res       = '0;
        stiff_sh      = CA_RST;
        mu_sh         = MU_RST;
        fbpk_sh       = FB_RST;
        n_err = 0; n_sent = 0; n_got = 0; n_slide = 0; n_fallback = 0;
        n_settings = 1;

        // typed rows: no load means fallback peak 16000 at reset settings
        dir_rows[0]  = '{16'sd0, 24'sd0, 23'd0, 1'b1, '{24'sd0, 1'b0, 1'b1}};
        dir_rows[1]  = '{16'sd25735, 24'sh800000, 23'd0, 1'b1,
                         '{-24'sd16000, 1'b1, 1'b1}};
        // -32768 is clamped to the largest angle
        dir_rows[2]  = '{-16'sd32768, 24'sd8388607, 23'd0, 1'b1,
                         '{24'sd16000, 1'b1, 1'b1}};
        dir_rows[3]  = '{16'sd32767, 24'sd0, 23'd0, 1'b1, '{-24'sd16000, 1'b1, 1'b1}};
        // full load, no drive force: peak equals the load
        dir_rows[4]  = '{16'sd25735, 24'sd0, 23'd8388607, 1'b1,
                         '{-24'sd8388607, 1'b1, 1'b0}};
        dir_rows[5]  = '{-16'sd25735, 24'sd0, 23'd8388607, 1'b1,
                         '{24'sd8388607, 1'b1, 1'b0}};
        // remaining rows go through the predictor
        dir_rows[6]  = '{16'sd1, 24'sd0, 23'd16000, 1'b0, '0};
        dir_rows[7]  = '{-16'sd1, 24'sd0, 23'd16000, 1'b0, '0};
        dir_rows[8]  = '{16'sd100, 24'sd1000, 23'd160000, 1'b0, '0};
        dir_rows[9]  = '{-16'sd500, -24'sd50000, 23'd160000, 1'b0, '0};
        dir_rows[10] = '{16'sd2000, 24'sd159999, 23'd160000, 1'b0, '0};
        dir_rows[11] = '{16'sd2000, 24'sd160000, 23'd160000, 1'b0, '0};
        dir_rows[12] = '{16'sd0, 24'sd100, 23'd5000000, 1'b0, '0};
        dir_rows[13] = '{16'sd16384, 24'sd0, 23'd800000, 1'b0, '0};
        dir_rows[14] = '{-16'sd10, 24'sd8388607, 23'd8388607, 1'b0, '0};
        dir_rows[15] = '{16'sd50, -24'sd1, 23'd1, 1'b0, '0};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_ROWS; r++)
            send(dir_rows[r].slip, dir_rows[r].fx, dir_rows[r].fz,
                 dir_rows[r].typed, dir_rows[r].res, GAP_LIGHT);
        start     <= 1'b0;
        row_typed <= 1'b0;

        random_phase(GAP_LIGHT);

        // all registers at their maximum: output clamp reachable
        drain();
        load_settings(24'hFF_FFFF, 16'hFFFF, 23'h7F_FFFF);
        random_phase(GAP_LIGHT);

        // all zero: zero peak on fallback, zero stiffness
        drain();
        load_settings(24'd0, 16'd0, 23'd0);
        random_phase(GAP_HEAVY);

        drain();
        load_settings(24'($urandom), 16'($urandom_range(4000, 40000)),
                      23'($urandom));
        random_phase(GAP_HEAVY);

        drain();
        load_settings(24'd2000, 16'd16384, 23'd1);
        random_phase(GAP_NONE);

        drain();
        if (force_q.size() != 0)
            report_mismatch("results never seen", force_q.size(), 0);
        $display("Ran %0d samples under %0d register settings, %0d results",
                 n_sent, n_settings, n_got);
        $display("Sliding branch %0d times, fallback peak %0d times",
                 n_slide, n_fallback);
        if (n_err == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
+incdir+hw/rtl
hw/rtl/btlf_pkg.sv
hw/rtl/btlf_tan.sv
hw/rtl/btlf_peak.sv
hw/rtl/btlf_shape.sv
hw/rtl/brush_tire_lateral_force_top.sv
dv/brush_tire_lateral_force_top_tb.sv
